@@ design/pic_pkg.sv @@
// Shared types, register map constants and helpers of the interrupt controller.
package pic_pkg;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_LINE  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [25:0] address;
      logic [31:0] write_data;
      logic [4:0]  source_id;
      logic        source_level;
   } req_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  irq_lines;
   } rsp_item_type;

   typedef struct packed {
      logic load_item;
      logic save_claim;
      logic apply;
      logic finish;
   } ctrl_cmd_type;

   localparam logic [25:0] PENDING_BASE = 26'h000_1000;
   localparam logic [25:0] EN_WORD_BASE = 26'h000_2000;
   localparam logic [25:0] CTX_BASE     = 26'h020_0000;
   localparam logic [11:0] CLAIM_OFFSET = 12'h004;
   localparam logic [11:0] THRESH_OFFSET = 12'h000;

   // ids 1..n exist, source zero never does
   function automatic logic [31:0] valid_mask(input int unsigned n);
      logic [31:0] m;
      m = '0;
      for (int i = 1; i < 32; i++) begin
         m[i] = (i <= n);
      end
      return m;
   endfunction

endpackage

@@ design/pic_if.sv @@
// Valid/ready channel interfaces for request and response items.
interface pic_req_if;
   import pic_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pic_rsp_if;
   import pic_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ design/platform_interrupt_controller_unit.sv @@
// Top level of the platform interrupt controller: sequencer plus datapath.
// Usage:
//   req_chan carries one item per handshake: a bus read, a bus write or a
//   source line update (opcode, address, write_data, source_id,
//   source_level). rsp_chan returns exactly one item per request with the
//   read data (claim id for a claim read, zero for writes and line updates)
//   and the interrupt line of contexts 0 and 1 as they stand after it.
//   Items are handled one at a time. An accepted item passes through the
//   claim search, the register update and the load of the response
//   register, in that order; the next request is taken once the response
//   register has been loaded. The search uses combinational arbiters: one
//   for the claim of the addressed context, used before the register
//   update, and one each for the lines of contexts 0 and 1, used after it.
//   The response register frees the request side: a new item is taken while
//   the previous response still waits; if rsp_chan stalls, the following
//   item waits in the load step until the register is taken.
//   Synchronous reset clears all priorities, enables, thresholds, pending,
//   in-service and line levels and empties the response register.
module platform_interrupt_controller_unit #(
   parameter int NUM_SOURCES   = 31,
   parameter int NUM_CONTEXTS  = 2,
   parameter int PRIORITY_BITS = 3
) (
   input logic      clock,
   input logic      reset,
   pic_req_if.sink  req_chan,
   pic_rsp_if.source rsp_chan
);
   import pic_pkg::*;

   ctrl_cmd_type cmd;

   pic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   pic_dpath #(
      .NUM_SOURCES   (NUM_SOURCES),
      .NUM_CONTEXTS  (NUM_CONTEXTS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_chan.payload),
      .rsp_item (rsp_chan.payload)
   );

endmodule

@@ design/pic_arb.sv @@
// Claim arbiter: highest priority above threshold, lowest id on ties.
module pic_arb #(
   parameter int PRIORITY_BITS = 3
) (
   input  logic [31:0]                    cand,
   input  logic [31:0][PRIORITY_BITS-1:0] prio,
   input  logic [PRIORITY_BITS-1:0]       thresh,
   output logic [4:0]                     best_id
);
   logic [31:0] keep;
   logic [31:0] plane;
   logic [31:0] hit;
   logic [31:0] first;

   always_comb begin
      keep = '0;
      for (int i = 0; i < 32; i++) begin
         keep[i] = cand[i] && (prio[i] > thresh);
      end
      // narrow to the maximum priority one bit plane at a time, MSB first
      for (int b = PRIORITY_BITS - 1; b >= 0; b--) begin
         for (int i = 0; i < 32; i++) begin
            plane[i] = prio[i][b];
         end
         hit = keep & plane;
         if (hit != '0) begin
            keep = hit;
         end
      end
      first = keep & (~keep + 32'd1);
      best_id = '0;
      for (int i = 0; i < 32; i++) begin
         if (first[i]) begin
            best_id = best_id | 5'(i);
         end
      end
   end

endmodule

@@ design/pic_ctrl.sv @@
// Sequencer: steps each item through search, apply and response load.
module pic_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pic_pkg::ctrl_cmd_type cmd
);
   import pic_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SEARCH;
         ST_SEARCH: state_in = ST_APPLY;
         ST_APPLY:  state_in = ST_FINISH;
         ST_FINISH: if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_SEARCH: cmd.save_claim = 1'b1;
         ST_APPLY:  cmd.apply      = 1'b1;
         ST_FINISH: cmd.finish     = slot_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_to_search: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SEARCH))
      else $error("accepted item did not move to search");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !slot_free) |=> (state_ff == ST_FINISH && rsp_valid_ff))
      else $error("finish left while response slot occupied");

endmodule

@@ design/pic_dpath.sv @@
// Register file, address decode, claim/complete and gateway logic, response register.
module pic_dpath #(
   parameter int NUM_SOURCES   = 31,
   parameter int NUM_CONTEXTS  = 2,
   parameter int PRIORITY_BITS = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pic_pkg::ctrl_cmd_type cmd,
   input  pic_pkg::req_item_type req_item,
   output pic_pkg::rsp_item_type rsp_item
);
   import pic_pkg::*;

   localparam int CTX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
   localparam logic [14:0] CTX_LIMIT = 15'(NUM_CONTEXTS);
   localparam logic [31:0] VALID = valid_mask(NUM_SOURCES);

   typedef enum logic [2:0] {
      RG_NONE,
      RG_PRIO,
      RG_PENDING,
      RG_ENABLE,
      RG_THRESH,
      RG_CLAIM
   } region_type;

   req_item_type                    item_ff, item_in;
   rsp_item_type                    rsp_ff, rsp_in;
   logic [31:0][PRIORITY_BITS-1:0]  prio_ff, prio_in;
   logic [31:0]                     pending_ff, pending_in;
   logic [31:0]                     insvc_ff, insvc_in;
   logic [31:0]                     level_ff, level_in;
   logic [31:0]                     enable_ff [NUM_CONTEXTS];
   logic [31:0]                     enable_in [NUM_CONTEXTS];
   logic [PRIORITY_BITS-1:0]        thr_ff [NUM_CONTEXTS];
   logic [PRIORITY_BITS-1:0]        thr_in [NUM_CONTEXTS];
   logic [31:0]                     rd_ff, rd_in;
   logic [4:0]                      claim_id_ff, claim_id_in;

   logic [25:0]       addr_w;
   logic [25:0]       erel;
   logic [25:0]       crel;
   logic [13:0]       ectx;
   logic [13:0]       cctx;
   logic [4:0]        pid;
   region_type        region;
   logic [CTX_W-1:0]  ctx_sel;
   logic [31:0]       read_value;
   logic [4:0]        claim_best;
   logic [4:0]        best0;
   logic [4:0]        best1;
   logic [1:0]        irq;
   logic [4:0]        done_id;
   logic [4:0]        sid;

   // ---- address decode of the held item
   always_comb begin
      addr_w  = {item_ff.address[25:2], 2'b00};
      erel    = addr_w - EN_WORD_BASE;
      crel    = addr_w - CTX_BASE;
      ectx    = erel[20:7];
      cctx    = crel[25:12];
      pid     = addr_w[6:2];
      region  = RG_NONE;
      ctx_sel = '0;
      if (addr_w < PENDING_BASE) begin
         if (addr_w[11:7] == 5'd0 && VALID[pid]) region = RG_PRIO;
      end else if (addr_w < EN_WORD_BASE) begin
         if (addr_w == PENDING_BASE) region = RG_PENDING;
      end else if (addr_w < CTX_BASE) begin
         if ({1'b0, ectx} < CTX_LIMIT && erel[6:2] == 5'd0) begin
            region  = RG_ENABLE;
            ctx_sel = ectx[CTX_W-1:0];
         end
      end else begin
         if ({1'b0, cctx} < CTX_LIMIT) begin
            if (crel[11:0] == THRESH_OFFSET) begin
               region  = RG_THRESH;
               ctx_sel = cctx[CTX_W-1:0];
            end else if (crel[11:0] == CLAIM_OFFSET) begin
               region  = RG_CLAIM;
               ctx_sel = cctx[CTX_W-1:0];
            end
         end
      end
   end

   always_comb begin
      case (region)
         RG_PRIO:    read_value = 32'(prio_ff[pid]);
         RG_PENDING: read_value = pending_ff & VALID;
         RG_ENABLE:  read_value = enable_ff[ctx_sel];
         RG_THRESH:  read_value = 32'(thr_ff[ctx_sel]);
         RG_CLAIM:   read_value = {27'd0, claim_id_ff};
         default:    read_value = '0;
      endcase
   end

   // ---- arbiters: addressed context for claims, contexts 0 and 1 for the lines
   pic_arb #(.PRIORITY_BITS(PRIORITY_BITS)) u_arb_claim (
      .cand    (pending_ff & enable_ff[ctx_sel] & VALID),
      .prio    (prio_ff),
      .thresh  (thr_ff[ctx_sel]),
      .best_id (claim_best)
   );

   pic_arb #(.PRIORITY_BITS(PRIORITY_BITS)) u_arb_ctx0 (
      .cand    (pending_ff & enable_ff[0] & VALID),
      .prio    (prio_ff),
      .thresh  (thr_ff[0]),
      .best_id (best0)
   );

   generate
      if (NUM_CONTEXTS > 1) begin : g_ctx1
         pic_arb #(.PRIORITY_BITS(PRIORITY_BITS)) u_arb_ctx1 (
            .cand    (pending_ff & enable_ff[1] & VALID),
            .prio    (prio_ff),
            .thresh  (thr_ff[1]),
            .best_id (best1)
         );
      end else begin : g_no_ctx1
         assign best1 = '0;
      end
   endgenerate

   assign irq = {best1 != 5'd0, best0 != 5'd0};

   // ---- next state
   always_comb begin
      item_in     = cmd.load_item ? req_item : item_ff;
      claim_id_in = cmd.save_claim ? claim_best : claim_id_ff;
      rsp_in      = cmd.finish ? rsp_item_type'{read_data: rd_ff, irq_lines: irq} : rsp_ff;
      prio_in     = prio_ff;
      pending_in  = pending_ff;
      insvc_in    = insvc_ff;
      level_in    = level_ff;
      enable_in   = enable_ff;
      thr_in      = thr_ff;
      rd_in       = rd_ff;
      done_id     = item_ff.write_data[4:0];
      sid         = item_ff.source_id;
      if (cmd.apply) begin
         rd_in = '0;
         case (opcode_type'(item_ff.opcode))
            OP_READ: begin
               rd_in = read_value;
               if (region == RG_CLAIM && claim_id_ff != 5'd0) begin
                  pending_in[claim_id_ff] = 1'b0;
                  insvc_in[claim_id_ff]   = 1'b1;
               end
            end
            OP_WRITE: begin
               case (region)
                  RG_PRIO:   prio_in[pid] = item_ff.write_data[PRIORITY_BITS-1:0];
                  RG_ENABLE: enable_in[ctx_sel] = item_ff.write_data & VALID;
                  RG_THRESH: thr_in[ctx_sel] = item_ff.write_data[PRIORITY_BITS-1:0];
                  RG_CLAIM: begin
                     // completion: ignored unless the id is enabled here and in service
                     if (item_ff.write_data[31:5] == 27'd0 && VALID[done_id] &&
                         enable_ff[ctx_sel][done_id] && insvc_ff[done_id]) begin
                        insvc_in[done_id] = 1'b0;
                        if (level_ff[done_id]) pending_in[done_id] = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            OP_LINE: begin
               if (VALID[sid]) begin
                  level_in[sid] = item_ff.source_level;
                  if (item_ff.source_level && !insvc_ff[sid]) pending_in[sid] = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_ff    <= '0;
         pending_ff <= '0;
         insvc_ff   <= '0;
         level_ff   <= '0;
         for (int c = 0; c < NUM_CONTEXTS; c++) begin
            enable_ff[c] <= '0;
            thr_ff[c]    <= '0;
         end
      end else begin
         prio_ff    <= prio_in;
         pending_ff <= pending_in;
         insvc_ff   <= insvc_in;
         level_ff   <= level_in;
         enable_ff  <= enable_in;
         thr_ff     <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      claim_id_ff <= claim_id_in;
      rd_ff       <= rd_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_item = rsp_ff;

   a_pend_svc_disjoint: assert property (@(posedge clock) disable iff (reset)
      (pending_ff & insvc_ff) == 32'd0)
      else $error("source both pending and in service");

   a_pend_valid_only: assert property (@(posedge clock) disable iff (reset)
      (pending_ff & ~VALID) == 32'd0)
      else $error("pending bit on absent source");

   a_claim_sets_svc: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && opcode_type'(item_ff.opcode) == OP_READ && region == RG_CLAIM &&
       claim_id_ff != 5'd0) |=> insvc_ff[claim_id_ff])
      else $error("claimed source not in service");

endmodule

@@ bench/pic_response_monitor.sv @@
// Watches both channels, predicts each response of the interrupt controller and compares.
module pic_response_monitor (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  pic_pkg::req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  pic_pkg::rsp_item_type rsp_item,
   output int unsigned  mismatches,
   output int unsigned  awaited,
   output int unsigned  checked,
   output int unsigned  claims_granted,
   output int unsigned  completions
);
   timeunit 1ns;
   timeprecision 1ps;
   import pic_pkg::*;

   localparam int N_CTX = 2;
   // sources 1..31 exist, source zero never does
   localparam logic [31:0] SRC_MASK = 32'hFFFF_FFFE;

   logic [2:0]  prio_m [32];
   logic [31:0] pend_m;
   logic [31:0] serv_m;
   logic [31:0] level_m;
   logic [31:0] en_m [N_CTX];
   logic [2:0]  thr_m [N_CTX];

   rsp_item_type expected_responses[$];
   rsp_item_type oldest;
   rsp_item_type fresh;

   // highest priority above threshold, lowest id on a tie
   function automatic logic [4:0] top_source(input int ctx);
      logic [31:0] cand;
      logic [4:0]  best;
      logic [2:0]  best_prio;
      int          id;
      cand = pend_m & en_m[ctx] & SRC_MASK;
      best = '0;
      best_prio = thr_m[ctx];
      for (id = 1; id < 32; id++) begin
         if (cand[id] && prio_m[id] > best_prio) begin
            best_prio = prio_m[id];
            best = 5'(id);
         end
      end
      return best;
   endfunction

   task automatic apply_request(input req_item_type it, output rsp_item_type exp_rsp);
      logic [25:0] a;
      logic [25:0] rel;
      logic [11:0] off;
      logic [31:0] bit_m;
      logic [4:0]  won;
      int          pid;
      int          rctx;
      bit          prio_hit, pend_hit, en_hit, thr_hit, claim_hit;
      a = {it.address[25:2], 2'b00};
      pid = 0;
      rctx = 0;
      prio_hit = 0;
      pend_hit = 0;
      en_hit = 0;
      thr_hit = 0;
      claim_hit = 0;
      if (a < PENDING_BASE) begin
         pid = int'(a[11:2]);
         prio_hit = (pid < 32) && SRC_MASK[pid];
      end else if (a < EN_WORD_BASE) begin
         pend_hit = (a == PENDING_BASE);
      end else if (a < CTX_BASE) begin
         rel = a - EN_WORD_BASE;
         rctx = int'(rel >> 7);
         // only the first enable word of each context exists
         en_hit = (rctx < N_CTX) && (rel[6:2] == 5'd0);
      end else begin
         rel = a - CTX_BASE;
         rctx = int'(rel >> 12);
         off = rel[11:0];
         thr_hit = (rctx < N_CTX) && (off == THRESH_OFFSET);
         claim_hit = (rctx < N_CTX) && (off == CLAIM_OFFSET);
      end

      exp_rsp.read_data = '0;
      case (it.opcode)
         OP_READ: begin
            if (prio_hit) begin
               exp_rsp.read_data = {29'd0, prio_m[pid]};
            end else if (pend_hit) begin
               exp_rsp.read_data = pend_m & SRC_MASK;
            end else if (en_hit) begin
               exp_rsp.read_data = en_m[rctx];
            end else if (thr_hit) begin
               exp_rsp.read_data = {29'd0, thr_m[rctx]};
            end else if (claim_hit) begin
               won = top_source(rctx);
               if (won != 5'd0) begin
                  pend_m[won] = 1'b0;
                  serv_m[won] = 1'b1;
                  claims_granted++;
               end
               exp_rsp.read_data = 32'(won);
            end
         end
         OP_WRITE: begin
            if (prio_hit) begin
               prio_m[pid] = it.write_data[2:0];
            end else if (en_hit) begin
               en_m[rctx] = it.write_data & SRC_MASK;
            end else if (thr_hit) begin
               thr_m[rctx] = it.write_data[2:0];
            end else if (claim_hit && it.write_data < 32'd32) begin
               bit_m = 32'd1 << it.write_data[4:0];
               if ((bit_m & SRC_MASK & en_m[rctx] & serv_m) != 32'd0) begin
                  serv_m &= ~bit_m;
                  // gateway re-forwards at once if the line is still up
                  if ((level_m & bit_m) != 32'd0) pend_m |= bit_m;
                  completions++;
               end
            end
         end
         OP_LINE: begin
            if (SRC_MASK[it.source_id]) begin
               bit_m = 32'd1 << it.source_id;
               if (it.source_level) begin
                  level_m |= bit_m;
                  if ((serv_m & bit_m) == 32'd0) pend_m |= bit_m;
               end else begin
                  level_m &= ~bit_m;
               end
            end
         end
         default: ;
      endcase
      exp_rsp.irq_lines = {top_source(1) != 5'd0, top_source(0) != 5'd0};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) prio_m[i] = '0;
         for (int c = 0; c < N_CTX; c++) begin
            en_m[c] = '0;
            thr_m[c] = '0;
         end
         pend_m = '0;
         serv_m = '0;
         level_m = '0;
         expected_responses.delete();
      end else begin
         // responses first: one taken at this edge belongs to an earlier item
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_responses.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response read_data %h irq_lines %b", $time,
                        rsp_item.read_data, rsp_item.irq_lines);
            end else begin
               oldest = expected_responses.pop_front();
               if (rsp_item.read_data !== oldest.read_data) begin
                  mismatches++;
                  $display("%0t: read_data expected %h got %h", $time,
                           oldest.read_data, rsp_item.read_data);
               end
               if (rsp_item.irq_lines !== oldest.irq_lines) begin
                  mismatches++;
                  $display("%0t: irq_lines expected %b got %b", $time,
                           oldest.irq_lines, rsp_item.irq_lines);
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_request(req_item, fresh);
            expected_responses.push_back(fresh);
         end
      end
      awaited = expected_responses.size();
   end

endmodule

@@ bench/tb_platform_interrupt_controller_unit.sv @@
// Stimulus, handshake pacing and verdict for the platform interrupt controller.
module tb_platform_interrupt_controller_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import pic_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET    = 1650;
   localparam int HOLD_CYCLES    = 150;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset;

   int unsigned mismatches, awaited, checked, claims_granted, completions;
   int unsigned sent = 0;
   int          idle_cycles = 0;
   bit          calm = 1'b0;

   always #1 clock = ~clock;

   pic_req_if req_chan ();
   pic_rsp_if rsp_chan ();

   platform_interrupt_controller_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pic_response_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_item       (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_item       (rsp_chan.payload),
      .mismatches     (mismatches),
      .awaited        (awaited),
      .checked        (checked),
      .claims_granted (claims_granted),
      .completions    (completions)
   );

   // mostly short gaps, now and then a long one; none in calm stretches
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   function automatic logic [25:0] prio_addr(input int id);
      return 26'(id * 4);
   endfunction

   function automatic logic [25:0] en_addr(input int ctx);
      return EN_WORD_BASE + 26'(ctx * 'h80);
   endfunction

   function automatic logic [25:0] thr_addr(input int ctx);
      return CTX_BASE + 26'(ctx * 'h1000);
   endfunction

   function automatic logic [25:0] claim_addr(input int ctx);
      return thr_addr(ctx) + 26'(CLAIM_OFFSET);
   endfunction

   // unused fields get random content; low address bits are don't-care
   function automatic req_item_type bus_item(input logic [1:0] op, input logic [25:0] addr,
                                             input logic [31:0] data);
      req_item_type it;
      it.opcode = op;
      it.address = addr | 26'($urandom_range(0, 3));
      it.write_data = data;
      it.source_id = 5'($urandom);
      it.source_level = 1'($urandom);
      return it;
   endfunction

   function automatic req_item_type line_item(input int id, input bit lvl);
      req_item_type it;
      it.opcode = OP_LINE;
      it.address = 26'($urandom);
      it.write_data = $urandom;
      it.source_id = 5'(id);
      it.source_level = lvl;
      return it;
   endfunction

   function automatic req_item_type noise_item();
      req_item_type it;
      it.opcode = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
         0: it.address = 26'($urandom);
         1: it.address = 26'($urandom_range(0, 'h3000));
         default: it.address = CTX_BASE + 26'($urandom_range(0, 'h3FFF));
      endcase
      it.write_data = $urandom;
      it.source_id = 5'($urandom);
      it.source_level = 1'($urandom);
      return it;
   endfunction

   // called just after a rising edge; returns at the edge that took the item
   task automatic offer(input req_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= it;
      do @(negedge clock); while (req_chan.ready !== 1'b1);
      @(posedge clock);
      sent++;
   endtask

   task automatic random_burst();
      int kind, id, id2, ctx;
      kind = $urandom_range(0, 99);
      id = $urandom_range(1, 31);
      id2 = $urandom_range(0, 31);
      ctx = $urandom_range(0, 1);
      if (kind < 50) begin
         // raise, claim, maybe drop, complete
         offer(line_item(id, 1'b1));
         if ($urandom_range(0, 1)) offer(line_item(id2, 1'b1));
         offer(bus_item(OP_READ, claim_addr(ctx), $urandom));
         if ($urandom_range(0, 1)) offer(line_item(id, 1'b0));
         case ($urandom_range(0, 9))
            0: offer(bus_item(OP_WRITE, claim_addr(ctx), $urandom));
            1, 2: offer(bus_item(OP_WRITE, claim_addr(ctx), 32'($urandom_range(0, 31))));
            default: offer(bus_item(OP_WRITE, claim_addr(ctx), 32'(id)));
         endcase
         if ($urandom_range(0, 3) == 0) offer(bus_item(OP_READ, claim_addr(1 - ctx), $urandom));
      end else if (kind < 70) begin
         case ($urandom_range(0, 3))
            0: offer(bus_item(OP_WRITE, prio_addr(id2), $urandom));
            1: offer(bus_item(OP_WRITE, en_addr(ctx), $urandom | $urandom));
            2: offer(bus_item(OP_WRITE, thr_addr(ctx),
                              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3)));
            default: offer(line_item(id2, 1'b0));
         endcase
      end else if (kind < 85) begin
         case ($urandom_range(0, 4))
            0: offer(bus_item(OP_READ, prio_addr($urandom_range(0, 63)), $urandom));
            1: offer(bus_item(OP_READ, PENDING_BASE, $urandom));
            2: offer(bus_item(OP_READ, en_addr(ctx), $urandom));
            3: offer(bus_item(OP_READ, thr_addr(ctx), $urandom));
            default: offer(bus_item(OP_READ, claim_addr($urandom_range(0, 3)), $urandom));
         endcase
      end else begin
         offer(noise_item());
      end
   endtask

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (idle_cycles < WATCHDOG_LIMIT);
      $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // response side: bursts of ready, random stalls, one long hold-off
   initial begin : rsp_pacing
      int stall;
      bit held;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!held && checked >= 400) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      offer(bus_item(OP_WRITE, prio_addr(1), 32'hFFFF_FFFF));   // wide write keeps low bits
      offer(bus_item(OP_WRITE, prio_addr(31), 32'd5));
      offer(bus_item(OP_WRITE, prio_addr(0), 32'd7));            // source zero
      offer(bus_item(OP_READ, prio_addr(0), $urandom));
      offer(bus_item(OP_READ, prio_addr(1), $urandom));
      offer(bus_item(OP_WRITE, en_addr(0), 32'hFFFF_FFFF));
      offer(bus_item(OP_WRITE, en_addr(1), 32'h8000_0002));
      offer(bus_item(OP_READ, en_addr(0), $urandom));
      offer(bus_item(OP_WRITE, thr_addr(0), 32'hFFFF_FFF8));
      offer(bus_item(OP_WRITE, thr_addr(1), 32'hFFFF_FFFC));
      offer(line_item(0, 1'b1));
      offer(line_item(1, 1'b1));
      offer(line_item(31, 1'b1));
      offer(bus_item(OP_WRITE, PENDING_BASE, 32'hFFFF_FFFF));
      offer(bus_item(OP_READ, PENDING_BASE, $urandom));
      offer(line_item(31, 1'b0));                                // dropped while pending
      offer(bus_item(OP_READ, claim_addr(0), $urandom));
      offer(bus_item(OP_READ, claim_addr(1), $urandom));
      offer(bus_item(OP_READ, claim_addr(1), $urandom));         // nothing left to claim
      offer(bus_item(OP_WRITE, claim_addr(0), 32'h40));
      offer(bus_item(OP_WRITE, claim_addr(1), 32'd3));
      offer(bus_item(OP_WRITE, claim_addr(0), 32'd1));           // line still high
      offer(bus_item(OP_WRITE, thr_addr(2), 32'd7));             // absent context
      offer(bus_item(OP_READ, en_addr(0) + 26'h4, $urandom));
      offer(bus_item(OP_UNUSED, 26'($urandom), $urandom));
      offer(bus_item(OP_READ, thr_addr(1), $urandom));

      while (sent < ITEM_TARGET) begin
         calm = (sent >= 700 && sent < 900);
         random_burst();
      end
      calm = 1'b0;
      req_chan.valid <= 1'b0;

      do @(negedge clock); while (awaited != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses: %0d claims granted, %0d completions.",
               sent, checked, claims_granted, completions);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
